[sv/hrke_pkg.sv]
// Shared constants, types and the usage-to-keycode table for the HID report decoder.
`default_nettype none
package hrke_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int MAP_ENTRIES = 102;
  localparam int MOD_COUNT   = 7;

  localparam int SLOT_FIELDS = 6;
  localparam int ROM_DEPTH   = 102;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);
  localparam int EVT_COUNT   = MOD_COUNT + 2 * KEY_SLOTS;

  localparam int IN_DATA_W   = 8 * (2 + SLOT_FIELDS);
  localparam int OUT_DATA_W  = 16;

  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  localparam logic EVT_KEY  = 1'b0;
  localparam logic EVT_SYNC = 1'b1;

  localparam logic [7:0] MOD_CODES [0:7] = '{
    8'd29, 8'd42, 8'd56, 8'd125, 8'd97, 8'd54, 8'd100, 8'd126
  };

  localparam logic [7:0] USAGE_ROM [0:ROM_DEPTH-1] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
    8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,
    8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
    8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,  8'd2,   8'd3,
    8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
    8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,
    8'd27,  8'd0,   8'd43,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,
    8'd53,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
    8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,  8'd99,  8'd70,
    8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
    8'd105, 8'd108, 8'd103, 8'd69,  8'd98,  8'd55,  8'd74,  8'd78,
    8'd96,  8'd79,  8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,
    8'd72,  8'd73,  8'd82,  8'd83,  8'd86,  8'd127
  };

  // One classified report, as handed from the front end to the sequencer.
  typedef struct packed {
    logic [MOD_COUNT-1:0]       mod_chg;
    logic [MOD_COUNT-1:0]       mod_now;
    logic [KEY_SLOTS-1:0]       rel;
    logic [KEY_SLOTS-1:0]       prs;
    logic [KEY_SLOTS-1:0][7:0]  old_keys;
    logic [KEY_SLOTS-1:0][7:0]  new_keys;
  } rpt_entry_t;

  function automatic logic [7:0] map_usage(input logic [7:0] u);
    logic [7:0] code;
    code = 8'd0;
    if ({1'b0, u} < 9'(ROM_DEPTH)) begin
      code = USAGE_ROM[u[ROM_AW-1:0]];
    end
    return code;
  endfunction

endpackage
`default_nettype wire

[sv/hid_report_to_key_events.sv]
// Top level of the boot keyboard report to key event decoder.
// Each input beat is one 8-byte boot keyboard report. It is diffed against the previous
// report (all zeros after reset) and turned into key press/release beats: changed modifier
// bits 0..6 in bit order, then per key slot a release for a vanished usage code and a press
// for a new one (usage codes 102 and above are ignored), then one sync beat with tlast set.
// The front end classifies a report in the cycle it is accepted and can take one report per
// cycle while its two-entry queue has room. The sequencer sends one event per cycle while
// out_tready allows it, and each report gives (number of events + 1) beats, 1 to 20, counting
// the sync beat, all driven by the single event sequencer through its output register.
`default_nettype none
module hid_report_to_key_events (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // modifier_bits, reserved_byte, key_slot0 .. key_slot5
  input  wire logic [hrke_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // key_code [7:0], pressed [8], zero pad
  output logic [hrke_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  // event_kind
  output logic                                  out_tuser
);
  import hrke_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_not_empty;
  rpt_entry_t  q_wdata;
  rpt_entry_t  q_rdata;

  hrke_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  hrke_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  hrke_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rdata     (q_rdata),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
`default_nettype wire

[sv/hrke_front.sv]
// Front end: accepts reports, diffs them against the previous report and classifies events.
`default_nettype none
module hrke_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [hrke_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                  q_push,
  output hrke_pkg::rpt_entry_t                  q_wdata,
  input  wire logic                             q_full
);
  import hrke_pkg::*;

  logic [7:0]                 prev_mods_r;
  logic [KEY_SLOTS-1:0][7:0]  prev_keys_r;
  logic [7:0]                 mods;
  logic [KEY_SLOTS-1:0][7:0]  keys;
  logic [KEY_SLOTS-1:0]       rel;
  logic [KEY_SLOTS-1:0]       prs;

  assign mods = in_tdata[7:0];

  // slots beyond the report's six bytes read as empty
  for (genvar gi = 0; gi < KEY_SLOTS; gi++) begin : g_slot
    if (gi < SLOT_FIELDS) begin : g_real
      assign keys[gi] = in_tdata[16 + 8 * gi +: 8];
    end else begin : g_pad
      assign keys[gi] = 8'd0;
    end
  end

  always_comb begin
    logic found_old;
    logic found_new;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      found_old = 1'b0;
      found_new = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (keys[j] == prev_keys_r[i]) found_old = 1'b1;
        if (prev_keys_r[j] == keys[i]) found_new = 1'b1;
      end
      rel[i] = (prev_keys_r[i] != 8'd0) && !found_old &&
               ({1'b0, prev_keys_r[i]} < 9'(MAP_ENTRIES));
      prs[i] = (keys[i] != 8'd0) && !found_new &&
               ({1'b0, keys[i]} < 9'(MAP_ENTRIES));
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_wdata.mod_chg  = mods[MOD_COUNT-1:0] ^ prev_mods_r[MOD_COUNT-1:0];
    q_wdata.mod_now  = mods[MOD_COUNT-1:0];
    q_wdata.rel      = rel;
    q_wdata.prs      = prs;
    q_wdata.old_keys = prev_keys_r;
    q_wdata.new_keys = keys;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mods_r <= 8'd0;
      prev_keys_r <= '0;
    end else if (q_push) begin
      prev_mods_r <= mods;
      prev_keys_r <= keys;
    end
  end

endmodule
`default_nettype wire

[sv/hrke_fifo.sv]
// Short queue of classified reports between the front end and the event sequencer.
`default_nettype none
module hrke_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire hrke_pkg::rpt_entry_t  wdata,
  output logic                       full,
  input  wire logic                  pop,
  output hrke_pkg::rpt_entry_t       rdata,
  output logic                       not_empty
);
  import hrke_pkg::*;

  rpt_entry_t        mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_CW-1:0]   count_r;

  assign full      = (count_r == Q_CW'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      if (push && !pop)      count_r <= count_r + Q_CW'(1);
      else if (pop && !push) count_r <= count_r - Q_CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full report queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("pop from empty report queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH)) else $error("report queue count out of range");

endmodule
`default_nettype wire

[sv/hrke_back.sv]
// Event sequencer: walks one classified report's pending events and drives the output register.
`default_nettype none
module hrke_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire hrke_pkg::rpt_entry_t             q_rdata,
  input  wire logic                             q_not_empty,
  output logic                                  q_pop,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [hrke_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tuser
);
  import hrke_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [EVT_COUNT-1:0]  pend_r, pend_nxt;
  rpt_entry_t            cur_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_code_r;
  logic                  out_pr_r;
  logic                  out_kind_r;
  logic                  out_last_r;

  logic                  adv;
  logic                  fire;
  logic                  do_sync;
  logic                  load;
  logic [EVT_COUNT-1:0]  pick;
  logic [EVT_COUNT-1:0]  load_pend;
  logic                  sel_mod;
  logic [7:0]            mod_code;
  logic [7:0]            usage;
  logic                  ev_pr;
  logic [7:0]            ev_code;

  assign adv     = !out_valid_r || out_tready;
  assign fire    = busy_r && adv;
  assign do_sync = fire && (pend_r == '0);
  assign load    = q_not_empty && (!busy_r || do_sync);
  assign q_pop   = load;

  // lowest pending event goes first: modifiers by bit, then release/press per slot
  assign pick = pend_r & (~pend_r + EVT_COUNT'(1));

  always_comb begin
    load_pend[MOD_COUNT-1:0] = q_rdata.mod_chg;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      load_pend[MOD_COUNT + 2 * i]     = q_rdata.rel[i];
      load_pend[MOD_COUNT + 2 * i + 1] = q_rdata.prs[i];
    end
  end

  always_comb begin
    sel_mod  = 1'b0;
    mod_code = 8'd0;
    usage    = 8'd0;
    ev_pr    = 1'b0;
    for (int b = 0; b < MOD_COUNT; b++) begin
      if (pick[b]) begin
        sel_mod  = 1'b1;
        mod_code = mod_code | MOD_CODES[b];
        ev_pr    = ev_pr | cur_r.mod_now[b];
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (pick[MOD_COUNT + 2 * i]) usage = usage | cur_r.old_keys[i];
      if (pick[MOD_COUNT + 2 * i + 1]) begin
        usage = usage | cur_r.new_keys[i];
        ev_pr = 1'b1;
      end
    end
    ev_code = sel_mod ? mod_code : map_usage(usage);
  end

  always_comb begin
    busy_nxt      = busy_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = busy_r;
    if (fire && !do_sync) pend_nxt = pend_r & ~pick;
    if (do_sync) busy_nxt = 1'b0;
    if (load) begin
      busy_nxt = 1'b1;
      pend_nxt = load_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= q_rdata;
    if (fire) begin
      out_kind_r <= do_sync ? EVT_SYNC : EVT_KEY;
      out_code_r <= do_sync ? 8'd0 : ev_code;
      out_pr_r   <= do_sync ? 1'b1 : ev_pr;
      out_last_r <= do_sync;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 9){1'b0}}, out_pr_r, out_code_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (pend_r == '0)) else $error("pending events while idle");
  a_sync_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata[8] && (out_tdata[7:0] == 8'd0))
    else $error("malformed sync beat");
  a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser) else $error("last beat is not sync");
  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !do_sync |-> $onehot(pick)) else $error("event pick not one-hot");

endmodule
`default_nettype wire

[tb/sv/tb_hid_report_to_key_events.sv]
// Self-checking testbench for the boot keyboard report to key event decoder.
`default_nettype none
module tb_hid_report_to_key_events;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS  = 6;
  localparam int NUM_MODS   = 7;
  localparam int MAP_LIMIT  = 102;
  localparam int RAND_ITEMS = 480;
  localparam int MAX_CYCLES = 400000;
  localparam int IDLE_PCT   = 28;

  // One boot report as it sits on in_tdata: mods lowest, slot 5 highest
  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] slot;
    logic [7:0]                reserved;
    logic [7:0]                mods;
  } hid_report_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic       pressed;
    logic       last;
  } key_evt_t;

  localparam logic [7:0] KEYCODE_OF_USAGE [0:MAP_LIMIT-1] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
    8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,
    8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
    8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,  8'd2,   8'd3,
    8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
    8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,
    8'd27,  8'd0,   8'd43,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,
    8'd53,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
    8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,  8'd99,  8'd70,
    8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
    8'd105, 8'd108, 8'd103, 8'd69,  8'd98,  8'd55,  8'd74,  8'd78,
    8'd96,  8'd79,  8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,
    8'd72,  8'd73,  8'd82,  8'd83,  8'd86,  8'd127
  };

  localparam logic [7:0] MOD_KEYCODE [0:7] = '{
    8'd29, 8'd42, 8'd56, 8'd125, 8'd97, 8'd54, 8'd100, 8'd126
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [hrke_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [hrke_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  hid_report_to_key_events dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  hid_report_t report_q[$];
  key_evt_t    pending_events[$];

  // decoder state as the predictor sees it
  logic [7:0] held_mods;
  logic [7:0] held_keys [NUM_SLOTS];

  logic in_taken = 1'b0;
  int   reports_in = 0;
  int   events_out = 0;
  int   presses = 0;
  int   releases = 0;
  int   longest_burst = 0;
  int   mismatches = 0;
  int   cycles = 0;
  logic calm;

  // no idling on either side through a block of reports mid-run
  assign calm = (reports_in >= 150) && (reports_in < 270);

  function automatic void note_event(logic [7:0] code, logic pressed);
    pending_events.push_back('{hrke_pkg::EVT_KEY, code, pressed, 1'b0});
    if (pressed) presses++;
    else releases++;
  endfunction

  function automatic void decode_report(hid_report_t rpt);
    int   count;
    logic found;
    logic was, now;
    count = pending_events.size();
    if (rpt.mods != held_mods) begin
      for (int b = 0; b < NUM_MODS; b++) begin
        was = held_mods[b];
        now = rpt.mods[b];
        if (was && !now) note_event(MOD_KEYCODE[b], 1'b0);
        if (!was && now) note_event(MOD_KEYCODE[b], 1'b1);
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (held_keys[i] != 8'd0) begin
        found = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
          if (rpt.slot[j] == held_keys[i]) found = 1'b1;
        if (!found && held_keys[i] < MAP_LIMIT)
          note_event(KEYCODE_OF_USAGE[held_keys[i]], 1'b0);
      end
      if (rpt.slot[i] != 8'd0) begin
        found = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
          if (held_keys[j] == rpt.slot[i]) found = 1'b1;
        if (!found && rpt.slot[i] < MAP_LIMIT)
          note_event(KEYCODE_OF_USAGE[rpt.slot[i]], 1'b1);
      end
    end
    pending_events.push_back('{hrke_pkg::EVT_SYNC, 8'd0, 1'b1, 1'b1});
    count = pending_events.size() - count;
    if (count > longest_burst) longest_burst = count;
    held_mods = rpt.mods;
    for (int i = 0; i < NUM_SLOTS; i++) held_keys[i] = rpt.slot[i];
  endfunction

  function automatic void flag_mismatch(string what, key_evt_t want, key_evt_t got,
                                        logic [6:0] pad);
    mismatches++;
    if (mismatches <= 10)
      $display({"[%0t] %s: want kind=%0d code=%0d pressed=%0d last=%0d,",
                " got kind=%0d code=%0d pressed=%0d last=%0d pad=%h"},
               $realtime, what, want.kind, want.code, want.pressed, want.last,
               got.kind, got.code, got.pressed, got.last, pad);
  endfunction

  task automatic queue_report(input logic [7:0] m, r, k0, k1, k2, k3, k4, k5);
    hid_report_t rpt;
    rpt.mods = m;
    rpt.reserved = r;
    rpt.slot[0] = k0;
    rpt.slot[1] = k1;
    rpt.slot[2] = k2;
    rpt.slot[3] = k3;
    rpt.slot[4] = k4;
    rpt.slot[5] = k5;
    report_q.push_back(rpt);
  endtask

  // driver: present reports at the falling edge, hold until taken
  always @(negedge clk) begin : drive
    logic nxt_valid;
    logic [hrke_pkg::IN_DATA_W-1:0] nxt_data;
    nxt_valid = in_tvalid;
    nxt_data = in_tdata;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_tvalid || in_taken) begin
      nxt_valid = 1'b0;
      if (report_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt_data = report_q.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata <= nxt_data;
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // input side: every accepted report goes through the predictor
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      decode_report(hid_report_t'(in_tdata));
      reports_in++;
    end
  end

  // monitor: compare each output beat with the oldest prediction
  always @(posedge clk) begin : monitor
    key_evt_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.code = out_tdata[7:0];
      got.pressed = out_tdata[8];
      got.last = out_tlast;
      events_out++;
      if (pending_events.size() == 0) begin
        flag_mismatch("unexpected beat", '0, got, out_tdata[15:9]);
      end else begin
        want = pending_events.pop_front();
        if (got != want || out_tdata[15:9] != 7'd0)
          flag_mismatch("event mismatch", want, got, out_tdata[15:9]);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Timed out after %0d cycles, %0d events still due", cycles,
               pending_events.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    hid_report_t gen;
    int pick;
    held_mods = 8'd0;
    for (int i = 0; i < NUM_SLOTS; i++) held_keys[i] = 8'd0;

    // directed reports
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // only bit seven changes: no key beats
    queue_report(8'h00, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h00, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    queue_report(8'h00, 8'h5A, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04);
    // unmapped codes, top of the map, first code past it
    queue_report(8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h31, 8'h65, 8'h66);
    queue_report(8'h00, 8'h00, 8'hFF, 8'h66, 8'h80, 8'h00, 8'h00, 8'h00);
    // duplicate codes across slots
    queue_report(8'h00, 8'h00, 8'h04, 8'h04, 8'h05, 8'h05, 8'h00, 8'h00);
    queue_report(8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
    // longest burst: every modifier and every slot turns over
    queue_report(8'h00, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    queue_report(8'h7F, 8'h00, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F);
    queue_report(8'h00, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    queue_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h55, 8'h00, 8'h2C, 8'h28, 8'h29, 8'h39, 8'h64, 8'h65);
    queue_report(8'hAA, 8'h00, 8'h65, 8'h64, 8'h39, 8'h29, 8'h28, 8'h2C);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    // random part: mostly typing-like evolution of the previous report
    gen = report_q[report_q.size()-1];
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(99);
      gen.reserved = 8'($urandom);
      if (pick < 70) begin
        if ($urandom_range(99) < 40) gen.mods[$urandom_range(7)] ^= 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if ($urandom_range(99) < 25) begin
            pick = $urandom_range(99);
            if (pick < 30) gen.slot[i] = 8'd0;
            else if (pick < 95) gen.slot[i] = 8'($urandom_range(4, MAP_LIMIT - 1));
            else gen.slot[i] = 8'($urandom);
          end
        end
      end else if (pick < 80) begin
        // same keys, reserved byte only
      end else if (pick < 88) begin
        gen.slot = '0;
        if ($urandom_range(1) != 0) gen.mods = 8'd0;
      end else begin
        gen = hid_report_t'({$urandom, $urandom});
      end
      report_q.push_back(gen);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (report_q.size() != 0 || in_tvalid || pending_events.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d reports: %0d event beats (%0d presses, %0d releases).",
             reports_in, events_out, presses, releases);
    $display("Longest report gave %0d beats; %0d mismatches.", longest_burst, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
